### design/mrb_pkg.sv
package mrb_pkg;

  localparam int unsigned MAX_COILS = 2000;
  localparam int unsigned MAX_REGS  = 125;
  localparam logic [7:0]  SLAVE_MAX = 8'd247;

  // Function codes
  localparam logic [7:0] FC_RD_COILS   = 8'h01;
  localparam logic [7:0] FC_RD_DISC    = 8'h02;
  localparam logic [7:0] FC_RD_HOLD    = 8'h03;
  localparam logic [7:0] FC_RD_INPUT   = 8'h04;
  localparam logic [7:0] FC_WR_COIL    = 8'h05;
  localparam logic [7:0] FC_WR_REG     = 8'h06;
  localparam logic [7:0] FC_WR_COILS   = 8'h0F;
  localparam logic [7:0] FC_WR_REGS    = 8'h10;

  localparam logic [7:0] COIL_ON_BYTE  = 8'hFF;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SLAVE = 2'd1;
  localparam logic [1:0] ST_BAD_QTY   = 2'd2;
  localparam logic [1:0] ST_NO_REQ    = 2'd3;

  localparam int unsigned CMD_BYTES  = 8;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  slave_id;
    logic [7:0]  func_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       frame_end;
  } result_t;

  // One unit of work for the byte sequencer: data bytes, then an optional CRC, or an error status.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [2:0]                nbytes;
    logic                      restart;
    logic                      send_crc;
    logic [1:0]                status;
  } cmd_t;

  typedef enum logic [4:0] {
    PK_NONE  = 5'b00001,
    PK_SCOIL = 5'b00010,
    PK_SREG  = 5'b00100,
    PK_MCOIL = 5'b01000,
    PK_MREG  = 5'b10000
  } pend_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### design/modbus_rtu_request_builder.sv
// Channel   Direction  Handshake                  Payload
// in_*      input      in_push / in_full          mrb_pkg::in_item_t (header or value)
// out_*     output     out_empty / out_pop        mrb_pkg::result_t  (one frame byte or error)
//
// An input transaction is classified in the cycle it is accepted and becomes at most one
// command in a two-entry queue; the byte sequencer then sends one result per cycle unless
// the output stalls, so a command yields one to eight results (eight for a read with CRC).
// The sequencer, with its CRC update of one byte per unstalled cycle, sets the throughput.
// Reset clears the pending request, the queue, the CRC and the output valid flag.
// A stalled output holds its result; the queue keeps taking input until it is full.
module modbus_rtu_request_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  mrb_pkg::in_item_t in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output mrb_pkg::result_t  out_result
);
  import mrb_pkg::*;

  logic    accept;
  logic    cmd_push, q_full, q_nempty, q_pop, res_vld;
  cmd_t    cmd_in, cmd_head;

  // The front updates its request state on every accepted transaction, independent
  // of how far the sequencer has got, so header and value items can arrive back to back.
  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign out_empty = !res_vld;

  mrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  mrb_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (q_pop),
    .full     (q_full),
    .nempty   (q_nempty),
    .head     (cmd_head)
  );

  // The sequencer owns the running CRC; a command that opens a frame restarts it.
  mrb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (q_nempty),
    .cmd     (cmd_head),
    .cmd_pop (q_pop),
    .res_pop (out_pop && res_vld),
    .res_vld (res_vld),
    .res     (out_result)
  );

endmodule

### design/mrb_front.sv
module mrb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  mrb_pkg::in_item_t item,
  output logic              cmd_push,
  output mrb_pkg::cmd_t     cmd
);
  import mrb_pkg::*;

  pend_t       pend_r, pend_nxt;
  logic [10:0] left_r, left_nxt;
  logic [7:0]  pack_r, pack_nxt;
  logic [2:0]  pos_r, pos_nxt;

  logic [7:0]  fc;
  logic        is_write, is_multi, is_coil, qty_ok;
  logic [15:0] qty;
  logic [16:0] qty_p7;
  logic [7:0]  byte_cnt, pack_new;
  logic [2:0]  pos_new;
  logic [10:0] left_dec;

  always_comb begin
    unique case (item.func_code) inside
      FC_RD_COILS, FC_RD_DISC, FC_RD_HOLD, FC_RD_INPUT,
      FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: fc = item.func_code;
      default:                                        fc = FC_RD_HOLD;
    endcase
    is_write = (fc == FC_WR_COIL) || (fc == FC_WR_REG) ||
               (fc == FC_WR_COILS) || (fc == FC_WR_REGS);
    is_multi = (fc == FC_WR_COILS) || (fc == FC_WR_REGS);
    is_coil  = (fc == FC_RD_COILS) || (fc == FC_RD_DISC) ||
               (fc == FC_WR_COIL) || (fc == FC_WR_COILS);
    qty      = (is_write && !is_multi) ? 16'd1 : item.quantity;
    qty_ok   = (qty != 16'd0) &&
               (qty <= (is_coil ? 16'(MAX_COILS) : 16'(MAX_REGS)));
    qty_p7   = {1'b0, qty} + 17'd7;
    byte_cnt = is_coil ? qty_p7[10:3] : {qty[6:0], 1'b0};
    pack_new = pack_r | ((item.value != 16'd0) ? (8'd1 << pos_r) : 8'd0);
    pos_new  = pos_r + 3'd1;
    left_dec = left_r - 11'd1;
  end

  always_comb begin
    pend_nxt = pend_r;
    left_nxt = left_r;
    pack_nxt = pack_r;
    pos_nxt  = pos_r;
    cmd      = '0;
    cmd_push = 1'b0;
    if (accept) begin
      cmd_push = 1'b1;
      if (!item.kind) begin
        pend_nxt = PK_NONE;
        left_nxt = '0;
        pack_nxt = '0;
        pos_nxt  = '0;
        if (item.slave_id == 8'd0 || item.slave_id > SLAVE_MAX) begin
          cmd.status = ST_BAD_SLAVE;
        end else if (!qty_ok) begin
          cmd.status = ST_BAD_QTY;
        end else begin
          cmd.restart  = 1'b1;
          cmd.bytes[0] = item.slave_id;
          cmd.bytes[1] = fc;
          cmd.bytes[2] = item.start_address[15:8];
          cmd.bytes[3] = item.start_address[7:0];
          cmd.bytes[4] = qty[15:8];
          cmd.bytes[5] = qty[7:0];
          cmd.bytes[6] = byte_cnt;
          if (!is_write) begin
            cmd.nbytes   = 3'd6;
            cmd.send_crc = 1'b1;
          end else if (!is_multi) begin
            cmd.nbytes = 3'd4;
            pend_nxt   = is_coil ? PK_SCOIL : PK_SREG;
            left_nxt   = 11'd1;
          end else begin
            cmd.nbytes = 3'd7;
            pend_nxt   = is_coil ? PK_MCOIL : PK_MREG;
            left_nxt   = qty[10:0];
          end
        end
      end else begin
        unique case (pend_r)
          PK_SCOIL: begin
            cmd.bytes[0] = (item.value != 16'd0) ? COIL_ON_BYTE : 8'h00;
            cmd.bytes[1] = 8'h00;
            cmd.nbytes   = 3'd2;
            cmd.send_crc = 1'b1;
            pend_nxt     = PK_NONE;
            left_nxt     = '0;
          end
          PK_SREG: begin
            cmd.bytes[0] = item.value[15:8];
            cmd.bytes[1] = item.value[7:0];
            cmd.nbytes   = 3'd2;
            cmd.send_crc = 1'b1;
            pend_nxt     = PK_NONE;
            left_nxt     = '0;
          end
          PK_MREG: begin
            cmd.bytes[0] = item.value[15:8];
            cmd.bytes[1] = item.value[7:0];
            cmd.nbytes   = 3'd2;
            cmd.send_crc = (left_dec == 11'd0);
            left_nxt     = left_dec;
            if (left_dec == 11'd0) begin
              pend_nxt = PK_NONE;
            end
          end
          PK_MCOIL: begin
            left_nxt = left_dec;
            if (pos_new == 3'd0 || left_dec == 11'd0) begin
              cmd.bytes[0] = pack_new;
              cmd.nbytes   = 3'd1;
              cmd.send_crc = (left_dec == 11'd0);
              pack_nxt     = '0;
              pos_nxt      = '0;
              if (left_dec == 11'd0) begin
                pend_nxt = PK_NONE;
              end
            end else begin
              // A coil that only adds a bit to the byte being packed.
              cmd_push = 1'b0;
              pack_nxt = pack_new;
              pos_nxt  = pos_new;
            end
          end
          default: begin
            cmd.status = ST_NO_REQ;
            pend_nxt   = PK_NONE;
            left_nxt   = '0;
            pack_nxt   = '0;
            pos_nxt    = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PK_NONE;
      left_r <= '0;
      pack_r <= '0;
      pos_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      left_r <= left_nxt;
      pack_r <= pack_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

### design/mrb_cmdq.sv
module mrb_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mrb_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          nempty,
  output mrb_pkg::cmd_t head
);
  import mrb_pkg::*;

  cmd_t                 mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign nempty = (cnt_r != '0);
  assign head   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

### design/mrb_back.sv
module mrb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_vld,
  input  mrb_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_pop,
  output logic             res_vld,
  output mrb_pkg::result_t res
);
  import mrb_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt, crc_cur;
  logic        vld_r, vld_nxt;
  result_t     res_r, res_nxt, step_res;
  logic [3:0]  total;
  logic        last, emit, is_data, is_lo;
  logic [7:0]  data_byte;

  assign res_vld = vld_r;
  assign res     = res_r;

  always_comb begin
    total     = (cmd.status != ST_OK) ? 4'd1
              : {1'b0, cmd.nbytes} + (cmd.send_crc ? 4'd2 : 4'd0);
    last      = ({1'b0, idx_r} == total - 4'd1);
    emit      = cmd_vld && (!vld_r || res_pop);
    cmd_pop   = emit && last;
    crc_cur   = (cmd.restart && idx_r == 3'd0) ? CRC_INIT : crc_r;
    is_data   = (idx_r < cmd.nbytes);
    is_lo     = (idx_r == cmd.nbytes);
    data_byte = cmd.bytes[idx_r];

    if (cmd.status != ST_OK) begin
      step_res = '{out_byte: 8'h00, byte_valid: 1'b0, status: cmd.status, frame_end: 1'b1};
    end else if (is_data) begin
      step_res = '{out_byte: data_byte, byte_valid: 1'b1, status: ST_OK, frame_end: 1'b0};
    end else if (is_lo) begin
      step_res = '{out_byte: crc_cur[7:0], byte_valid: 1'b1, status: ST_OK, frame_end: 1'b0};
    end else begin
      step_res = '{out_byte: crc_cur[15:8], byte_valid: 1'b1, status: ST_OK, frame_end: 1'b1};
    end

    idx_nxt = idx_r;
    crc_nxt = crc_r;
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (res_pop) begin
      vld_nxt = 1'b0;
    end
    if (emit) begin
      vld_nxt = 1'b1;
      res_nxt = step_res;
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
      if (cmd.status != ST_OK || (!is_data && !is_lo)) begin
        crc_nxt = CRC_INIT;
      end else if (is_data) begin
        crc_nxt = crc_byte(crc_cur, data_byte);
      end else begin
        crc_nxt = crc_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      crc_r <= CRC_INIT;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

### design/mrb_checker.sv
module mrb_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_push,
  input logic             in_full,
  input logic             out_empty,
  input logic             out_pop,
  input mrb_pkg::result_t out_result
);
  import mrb_pkg::*;

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result)))
    else $error("result changed while stalled");

  // Frame bytes carry status ok; every error result carries no byte.
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_result.byte_valid == (out_result.status == ST_OK)))
    else $error("byte_valid disagrees with status");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_result.byte_valid) |->
      (out_result.out_byte == 8'h00 && out_result.frame_end))
    else $error("error result malformed");

  a_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (out_empty && !in_full))
    else $error("not empty after reset");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |=> (in_full || !out_empty))
    else $error("queue freed with nothing to deliver");

endmodule

bind modbus_rtu_request_builder mrb_checker u_mrb_checker (.*);
